// ===== src/stt_pkg.sv =====
// Shared types, codes and character classes for the source text tokenizer.
// Used by stt_dp, stt_ctrl and source_text_tokenizer_top; depends on nothing.

package stt_pkg;

  localparam int CHAR_W      = 8;
  localparam int KIND_W      = 5;
  localparam int KW_COUNT    = 7;
  localparam int KW_MAX_LEN  = 5;

  // Scan modes of the open token
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_IDENT  = 2'd3;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_STRING  = 5'd1;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd3;
  localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd4;
  localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd5;
  localparam logic [KIND_W-1:0] KIND_MULT    = 5'd6;
  localparam logic [KIND_W-1:0] KIND_DIV     = 5'd7;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd8;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd9;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd10;
  localparam logic [KIND_W-1:0] KIND_KW_BASE = 5'd11;
  localparam logic [KIND_W-1:0] KIND_EOF     = 5'd18;
  // Operator lookup miss (no operator ever has the number kind)
  localparam logic [KIND_W-1:0] KIND_NONE    = 5'd0;

  // Input op codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOT  = 1'b1;

  // Characters with a special meaning
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;

  typedef logic [KW_COUNT-1:0] kw_match_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;         // latch the input item
    logic plan;         // decide the item, append or update the token count
    logic rd;           // read the buffer at the emit index
    logic load_char;    // load one buffered character into the output register
    logic load_empty;   // load an empty-valued result of the closed token
    logic load_follow;  // load the operator or end-of-text result
    logic apply;        // commit the next scan state
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic append;       // character joins the open token
    logic close;        // open token gets emitted
    logic empty;        // open token holds no character
    logic plan_follow;  // a single result follows the closed token (decide cycle)
    logic follow;       // same, as registered at the decide cycle
    logic last_char;    // emit index is at the last buffered character
    logic out_free;     // output register can take a result
  } dp_stat_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_word(input logic [CHAR_W-1:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      8'h3D:   k = KIND_ASSIGN;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_MULT;
      8'h2F:   k = KIND_DIV;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h2C:   k = KIND_COMMA;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Keyword text, left aligned, padded with zero bytes
  function automatic logic [KW_MAX_LEN*CHAR_W-1:0] kw_text(input logic [2:0] k);
    logic [KW_MAX_LEN*CHAR_W-1:0] t;
    case (k)
      3'd0:    t = "print";
      3'd1:    t = {"if", 24'h0};
      3'd2:    t = {"else", 8'h0};
      3'd3:    t = {"for", 16'h0};
      3'd4:    t = {"in", 24'h0};
      3'd5:    t = {"def", 16'h0};
      3'd6:    t = "range";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0:    n = 3'd5;
      3'd1:    n = 3'd2;
      3'd2:    n = 3'd4;
      3'd3:    n = 3'd3;
      3'd4:    n = 3'd2;
      3'd5:    n = 3'd3;
      3'd6:    n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Character of keyword k at position pos (zero past its end)
  function automatic logic [CHAR_W-1:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [KW_MAX_LEN*CHAR_W-1:0] t;
    logic [CHAR_W-1:0]            c;
    t = kw_text(k);
    case (pos)
      3'd0:    c = t[39:32];
      3'd1:    c = t[31:24];
      3'd2:    c = t[23:16];
      3'd3:    c = t[15:8];
      3'd4:    c = t[7:0];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== src/stt_dp.sv =====
// Datapath of the source text tokenizer: input latch, scan state, token buffer
// memory, keyword match tracking and the output register. Uses stt_pkg.

module stt_dp
  import stt_pkg::*;
#(
  parameter int TOKEN_TEXT_MAX = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               in_op,
  input  logic [CHAR_W-1:0]  in_char,
  input  logic [7:0]         token_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_kind,
  output logic [CHAR_W-1:0]  out_char,
  output logic               out_char_valid,
  output logic               out_token_end,
  output logic               out_run_last
);

  localparam int DEPTH = TOKEN_TEXT_MAX - 1;
  localparam int AW    = $clog2(TOKEN_TEXT_MAX);
  localparam logic [AW-1:0] CAP = AW'(TOKEN_TEXT_MAX - 1);

  // Latched input item
  logic              op_r;
  logic [CHAR_W-1:0] char_r;

  // Scan state
  logic [1:0]    mode;
  logic          quote;
  logic [AW-1:0] len;
  logic [7:0]    count;
  kw_match_t     match;

  // Emission
  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rd_data;
  logic [AW-1:0]     idx;

  // Plan registered at the decide cycle
  logic              p_follow;
  logic [KIND_W-1:0] p_follow_kind;
  logic [1:0]        p_start_mode;
  logic              p_start_quote;
  logic [KIND_W-1:0] close_kind_r;

  // Decide logic
  logic [CHAR_W-1:0] q_char;
  logic              grow;
  logic              app;
  logic              quote_end;
  logic              close;
  logic [7:0]        cnt1;
  logic              fresh;
  logic [KIND_W-1:0] c_op;
  logic              follow;
  logic [KIND_W-1:0] follow_kind;
  logic [1:0]        start_mode;
  logic              start_quote;
  logic [7:0]        count_next;
  logic [KIND_W-1:0] close_kind;
  kw_match_t         match_app;
  kw_match_t         match_init;
  logic              p_keep;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic              last_char;
  logic              load_any;

  // Classify the latched item against the open token
  always_comb begin
    q_char = quote ? CH_SQUOTE : CH_DQUOTE;
    case (mode)
      MODE_STRING: grow = (char_r != q_char);
      MODE_NUMBER: grow = is_digit(char_r);
      MODE_IDENT:  grow = is_word(char_r);
      default:     grow = 1'b0;
    endcase
    app       = (op_r == OP_CHAR) && grow && (len != CAP);
    quote_end = (op_r == OP_CHAR) && (mode == MODE_STRING) && (char_r == q_char);
    close     = (mode != MODE_IDLE) && !app;
    cnt1      = count + {7'd0, close};
    fresh     = (op_r == OP_CHAR) && !app && !quote_end && (cnt1 < token_limit);
    c_op      = op_kind(char_r);

    if (op_r == OP_EOT) begin
      follow      = 1'b1;
      follow_kind = KIND_EOF;
    end else begin
      follow      = fresh && (c_op != KIND_NONE);
      follow_kind = c_op;
    end

    start_mode = MODE_IDLE;
    if (fresh) begin
      if ((char_r == CH_DQUOTE) || (char_r == CH_SQUOTE)) begin
        start_mode = MODE_STRING;
      end else if (is_digit(char_r)) begin
        start_mode = MODE_NUMBER;
      end else if (is_alpha(char_r) || (char_r == CH_UNDER)) begin
        start_mode = MODE_IDENT;
      end
    end
    start_quote = fresh && (char_r == CH_SQUOTE);
    count_next  = (op_r == OP_EOT) ? 8'd0 : (cnt1 + {7'd0, follow});
  end

  // Track keyword prefixes as characters arrive, resolve at close
  always_comb begin
    close_kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      match_app[k]  = match[k] && (len < AW'(KW_MAX_LEN)) &&
                      (kw_char(3'(k), len[2:0]) == char_r);
      match_init[k] = (kw_char(3'(k), 3'd0) == char_r);
      if (match[k] && (len == AW'(kw_len(3'(k))))) begin
        close_kind = KIND_KW_BASE + KIND_W'(k);
      end
    end
    case (mode)
      MODE_STRING: close_kind = KIND_STRING;
      MODE_NUMBER: close_kind = KIND_NUMBER;
      default:     ;
    endcase
  end

  assign p_keep    = (p_start_mode == MODE_NUMBER) || (p_start_mode == MODE_IDENT);
  assign mem_we    = (cmd.plan && app) || (cmd.apply && p_keep);
  assign mem_wa    = cmd.apply ? '0 : len;
  assign last_char = (idx == (len - 1'b1));
  assign load_any  = cmd.load_char || cmd.load_empty || cmd.load_follow;

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= in_op;
      char_r <= in_char;
    end
  end

  // Token buffer: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= char_r;
    end
    if (cmd.rd) begin
      rd_data <= mem[idx];
    end
  end

  // Scan state, plan and emit index
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      quote         <= 1'b0;
      len           <= '0;
      count         <= '0;
      match         <= '0;
      idx           <= '0;
      p_follow      <= 1'b0;
      p_follow_kind <= KIND_NONE;
      p_start_mode  <= MODE_IDLE;
      p_start_quote <= 1'b0;
      close_kind_r  <= KIND_NONE;
    end else begin
      if (cmd.plan) begin
        count         <= count_next;
        p_follow      <= follow;
        p_follow_kind <= follow_kind;
        p_start_mode  <= start_mode;
        p_start_quote <= start_quote;
        close_kind_r  <= close_kind;
        if (app) begin
          len   <= len + 1'b1;
          match <= match_app;
        end
      end
      if (cmd.load_char) begin
        idx <= last_char ? '0 : (idx + 1'b1);
      end
      if (cmd.apply) begin
        mode  <= p_start_mode;
        quote <= p_start_quote;
        len   <= p_keep ? AW'(1) : '0;
        match <= match_init;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      out_kind       <= close_kind_r;
      out_char       <= rd_data;
      out_char_valid <= 1'b1;
      out_token_end  <= last_char;
      out_run_last   <= last_char && !p_follow;
    end else if (cmd.load_empty) begin
      out_kind       <= close_kind_r;
      out_char       <= '0;
      out_char_valid <= 1'b0;
      out_token_end  <= 1'b1;
      out_run_last   <= !p_follow;
    end else if (cmd.load_follow) begin
      out_kind       <= p_follow_kind;
      out_char       <= '0;
      out_char_valid <= 1'b0;
      out_token_end  <= 1'b1;
      out_run_last   <= 1'b1;
    end
  end

  // Status to the controller
  always_comb begin
    stat.append      = app;
    stat.close       = close;
    stat.empty       = (len == '0);
    stat.plan_follow = follow;
    stat.follow      = p_follow;
    stat.last_char   = last_char;
    stat.out_free    = !out_valid || out_ready;
  end

endmodule

// ===== src/stt_ctrl.sv =====
// Controller of the source text tokenizer: sequences decide, token emission,
// the trailing single result and the state commit. Uses stt_pkg.

module stt_ctrl
  import stt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_WR     = 3'd3;
  localparam logic [2:0] S_EMPTY  = 3'd4;
  localparam logic [2:0] S_FOLLOW = 3'd5;
  localparam logic [2:0] S_APPLY  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.plan = 1'b1;
        if (stat.append) begin
          state_next = S_IDLE;
        end else if (stat.close) begin
          state_next = stat.empty ? S_EMPTY : S_RD;
        end else if (stat.plan_follow) begin
          state_next = S_FOLLOW;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        if (stat.out_free) begin
          cmd.load_char = 1'b1;
          if (stat.last_char) begin
            state_next = stat.follow ? S_FOLLOW : S_APPLY;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.load_empty = 1'b1;
          state_next     = stat.follow ? S_FOLLOW : S_APPLY;
        end
      end
      S_FOLLOW: begin
        if (stat.out_free) begin
          cmd.load_follow = 1'b1;
          state_next      = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/source_text_tokenizer_top.sv =====
// Top level of the source text tokenizer: stream ports, configuration register
// and the controller/datapath pair. Uses stt_pkg, stt_ctrl and stt_dp.
//
//   Channel   Direction  Handshake        Payload
//   s_*       in         s_tvalid/tready  tdata char_in, tuser op
//   m_*       out        m_tvalid/tready  tdata value_char, tuser kind/flags, tlast
//   APB       in         psel/penable     token_limit at byte address 0
//
// A text character that extends the open token is taken and decided; any other item
// also goes through a buffer read and an output load per character of a closed token
// (a single load for an empty token), a load for a trailing operator or end-of-text
// result, and the state commit. The read and load of a character do not overlap.
// Reset is synchronous; no clearing pass is needed. s_tready stays low while an
// item is in work; a stalled m_tready holds the emission loop in place.

module source_text_tokenizer_top
  import stt_pkg::*;
#(
  parameter int TOKEN_TEXT_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tuser,   // [0] op
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] value_char
  output logic [6:0]  m_tuser,   // [4:0] token_kind, [5] char_valid, [6] token_end
  output logic        m_tlast,   // run_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_TOKEN_LIMIT = 1'b0;

  logic [7:0]        token_limit;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [KIND_W-1:0] out_kind;
  logic              out_char_valid;
  logic              out_token_end;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOKEN_LIMIT) ? {24'd0, token_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_limit <= 8'd128;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOKEN_LIMIT)) begin
      token_limit <= pwdata[7:0];
    end
  end

  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stt_dp #(
    .TOKEN_TEXT_MAX (TOKEN_TEXT_MAX)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (s_tuser),
    .in_char        (s_tdata),
    .token_limit    (token_limit),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_kind       (out_kind),
    .out_char       (m_tdata),
    .out_char_valid (out_char_valid),
    .out_token_end  (out_token_end),
    .out_run_last   (m_tlast)
  );

  assign m_tuser = {out_token_end, out_char_valid, out_kind};

  // An accepted item holds s_tready low on the next clock
  a_take_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on two consecutive cycles");

  // The last result of a run always closes a token
  a_last_ends_token: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser[6])
    else $error("run ends inside a token");

  // An empty value carries a zero character
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[5]) |-> (m_tdata == 8'd0))
    else $error("empty value with nonzero character");

  // End of text is the last result of its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[4:0] == KIND_EOF)) |-> (m_tlast && !m_tuser[5]))
    else $error("end-of-text result not last or carries a character");

endmodule

// ===== dv/source_text_tokenizer_top_tb.sv =====
// Self-checking testbench for source_text_tokenizer_top: streams text bytes and
// end-of-text items, predicts every token result in SystemVerilog and checks the
// output stream. Depends on stt_pkg and the RTL under src only.

module source_text_tokenizer_top_tb;
  import stt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TEXT_MAX    = 64;
  localparam int          TEXT_CAP    = TEXT_MAX - 1;
  localparam logic [2:0]  LIMIT_ADDR  = 3'd0;
  localparam int          SETTLE_CYC  = 20;
  localparam int          PHASE_ITEMS = 12;
  localparam int          MAX_REPORTS = 20;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] ch;
  } text_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic              vld;
    logic              tend;
    logic              last;
  } tok_res_t;

  // Token shapes for the random text generator
  typedef enum int {
    SH_KEYWORD, SH_IDENT, SH_NUMBER, SH_STRING, SH_OPER, SH_NOISE, SH_LONG, SH_BLANK
  } shape_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = OP_CHAR;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [7:0]  m_tdata;
  wire  [6:0]  m_tuser;
  wire         m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  source_text_tokenizer_top #(.TOKEN_TEXT_MAX(TEXT_MAX)) DUT (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectation stores
  text_item_t text_q[$];
  tok_res_t   token_q[$];
  tok_res_t   step_res[$];

  int stim_items  = 0;
  int res_checked = 0;
  int errors      = 0;
  int s_gap = 0, s_run = 0, r_gap = 0, r_run = 0;
  text_item_t drv_item;
  tok_res_t   got, want;

  // Predictor state
  logic [7:0]        cfg_limit = 8'd128;
  logic [1:0]        lx_mode   = MODE_IDLE;
  logic              lx_quote  = 1'b0;
  logic [CHAR_W-1:0] lx_buf [TEXT_CAP];
  int                lx_len    = 0;
  logic [7:0]        lx_count  = '0;

  string keyword_str [7] = '{"print", "if", "else", "for", "in", "def", "range"};
  string word_set = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
  string oper_set = "=+-*/(),";
  string blank_set = " \t\n\r";

  function automatic logic digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic blank_ch(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic word_ch(logic [7:0] c);
    return alpha_ch(c) || digit_ch(c) || c == "_";
  endfunction

  function automatic logic [KIND_W-1:0] oper_kind(logic [7:0] c);
    case (c)
      "=":     return KIND_ASSIGN;
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      "*":     return KIND_MULT;
      "/":     return KIND_DIV;
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      ",":     return KIND_COMMA;
      default: return KIND_NONE;
    endcase
  endfunction

  function automatic void put_empty(logic [KIND_W-1:0] kind);
    step_res.push_back('{kind: kind, ch: '0, vld: 1'b0, tend: 1'b1, last: 1'b0});
  endfunction

  // Keyword lookup on the buffered identifier
  function automatic logic [KIND_W-1:0] word_kind();
    logic hit;
    for (int k = 0; k < 7; k++) begin
      if (keyword_str[k].len() == lx_len) begin
        hit = 1'b1;
        for (int i = 0; i < lx_len; i++)
          if (lx_buf[i] != keyword_str[k][i]) hit = 1'b0;
        if (hit) return KIND_W'(KIND_KW_BASE + k);
      end
    end
    return KIND_IDENT;
  endfunction

  // Emit the open token, one result per buffered character or one empty result
  function automatic void close_token();
    logic [KIND_W-1:0] kind;
    if (lx_mode == MODE_IDLE) return;
    if (lx_mode == MODE_STRING) kind = KIND_STRING;
    else if (lx_mode == MODE_NUMBER) kind = KIND_NUMBER;
    else kind = word_kind();
    if (lx_len == 0) put_empty(kind);
    for (int i = 0; i < lx_len; i++)
      step_res.push_back('{kind: kind, ch: lx_buf[i], vld: 1'b1,
                           tend: (i == lx_len - 1), last: 1'b0});
    lx_count = lx_count + 8'd1;
    lx_mode  = MODE_IDLE;
    lx_len   = 0;
    lx_quote = 1'b0;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    logic [KIND_W-1:0] k;
    // extend or close the open token
    if (lx_mode == MODE_STRING) begin
      if (c == (lx_quote ? CH_SQUOTE : CH_DQUOTE)) begin
        close_token();
        return;
      end
      if (lx_len < TEXT_CAP) begin
        lx_buf[lx_len] = c;
        lx_len++;
        return;
      end
      close_token();
    end else if (lx_mode == MODE_NUMBER) begin
      if (digit_ch(c) && lx_len < TEXT_CAP) begin
        lx_buf[lx_len] = c;
        lx_len++;
        return;
      end
      close_token();
    end else if (lx_mode == MODE_IDENT) begin
      if (word_ch(c) && lx_len < TEXT_CAP) begin
        lx_buf[lx_len] = c;
        lx_len++;
        return;
      end
      close_token();
    end
    // start a new token unless the limit is reached or the byte is blank
    if (lx_count >= cfg_limit || blank_ch(c)) return;
    if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      lx_quote = (c == CH_SQUOTE);
      lx_mode  = MODE_STRING;
      lx_len   = 0;
    end else if (digit_ch(c)) begin
      lx_mode   = MODE_NUMBER;
      lx_buf[0] = c;
      lx_len    = 1;
    end else if (alpha_ch(c) || c == "_") begin
      lx_mode   = MODE_IDENT;
      lx_buf[0] = c;
      lx_len    = 1;
    end else begin
      k = oper_kind(c);
      if (k != KIND_NONE) begin
        put_empty(k);
        lx_count = lx_count + 8'd1;
      end
    end
  endfunction

  // Work out the results of one accepted item and queue them
  function automatic void predict_item(text_item_t itm);
    step_res.delete();
    if (itm.op == OP_EOT) begin
      close_token();
      put_empty(KIND_EOF);
      lx_mode  = MODE_IDLE;
      lx_quote = 1'b0;
      lx_len   = 0;
      lx_count = '0;
    end else begin
      scan_char(itm.ch);
    end
    foreach (step_res[i]) begin
      if (i == step_res.size() - 1) step_res[i].last = 1'b1;
      token_q.push_back(step_res[i]);
    end
  endfunction

  // Mostly short gaps, a few long ones, and stretches with none
  function automatic int pick_gap(inout int run);
    int r;
    if (run > 0) begin
      run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      run = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Sender: advance to the next item once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_gap    <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_gap > 0) begin
        s_tvalid <= 1'b0;
        s_gap    <= s_gap - 1;
      end else if (text_q.size() > 0) begin
        drv_item = text_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= drv_item.ch;
        s_tuser  <= drv_item.op;
        s_gap    <= pick_gap(s_run);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random after each accepted result
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      r_gap    <= 0;
    end else if (r_gap > 0) begin
      m_tready <= 1'b0;
      r_gap    <= r_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if (m_tvalid && m_tready) r_gap <= pick_gap(r_run);
    end
  end

  // Check results, track register writes, predict accepted items
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser[4:0], m_tdata, m_tuser[5], m_tuser[6], m_tlast};
        if (token_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result kind=%0d char=%02h valid=%0b end=%0b last=%0b",
                     $time, got.kind, got.ch, got.vld, got.tend, got.last);
        end else begin
          want = token_q.pop_front();
          res_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"%0t: mismatch: expected kind=%0d char=%02h valid=%0b end=%0b last=%0b,",
                        " got kind=%0d char=%02h valid=%0b end=%0b last=%0b"}, $time,
                       want.kind, want.ch, want.vld, want.tend, want.last,
                       got.kind, got.ch, got.vld, got.tend, got.last);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        cfg_limit = pwdata[7:0];
      if (s_tvalid && s_tready)
        predict_item('{op: s_tuser, ch: s_tdata});
    end
  end

  function automatic void put_char(logic [7:0] c);
    text_q.push_back('{op: OP_CHAR, ch: c});
    stim_items++;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void put_eot();
    text_q.push_back('{op: OP_EOT, ch: 8'($urandom_range(0, 255))});
    stim_items++;
  endfunction

  function automatic void put_word(int len, logic alnum);
    put_char(word_set[$urandom_range(0, 52)]);
    for (int i = 1; i < len; i++)
      put_char(alnum ? word_set[$urandom_range(0, 62)] : word_set[$urandom_range(53, 62)]);
  endfunction

  function automatic void put_digits(int len);
    for (int i = 0; i < len; i++) put_char(word_set[$urandom_range(53, 62)]);
  endfunction

  // Quoted string with random bytes that never match the closing quote
  function automatic void put_string(int len, logic closed);
    logic [7:0] q, c;
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    put_char(q);
    for (int i = 0; i < len; i++) begin
      c = 8'($urandom_range(0, 255));
      put_char(c == q ? c + 8'd1 : c);
    end
    if (closed) put_char(q);
  endfunction

  function automatic void put_random_token();
    shape_e sh;
    int     r;
    r = $urandom_range(0, 99);
    sh = shape_e'(r < 15 ? SH_KEYWORD : r < 35 ? SH_IDENT : r < 50 ? SH_NUMBER :
                  r < 62 ? SH_STRING : r < 78 ? SH_OPER : r < 86 ? SH_NOISE :
                  r < 89 ? SH_LONG : SH_BLANK);
    case (sh)
      SH_KEYWORD: begin
        put_text(keyword_str[$urandom_range(0, 6)]);
        if ($urandom_range(0, 3) == 0) put_char(word_set[$urandom_range(0, 62)]);
      end
      SH_IDENT:   put_word($urandom_range(1, 8), 1'b1);
      SH_NUMBER:  put_digits($urandom_range(1, 6));
      SH_STRING:  put_string($urandom_range(0, 8), $urandom_range(0, 9) != 0);
      SH_OPER:    put_char(oper_set[$urandom_range(0, 7)]);
      SH_NOISE:   put_char(8'($urandom_range(0, 255)));
      SH_LONG: begin
        r = $urandom_range(0, 2);
        if (r == 0) put_digits($urandom_range(60, 66));
        else if (r == 1) put_word($urandom_range(60, 66), 1'b1);
        else put_string($urandom_range(60, 66), 1'b1);
      end
      default:    put_char(blank_set[$urandom_range(0, 3)]);
    endcase
    // separate words most of the time
    if (sh inside {SH_KEYWORD, SH_IDENT, SH_NUMBER} && $urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 1)) put_char(" ");
      else put_char(oper_set[$urandom_range(0, 7)]);
    end
  endfunction

  task automatic wait_drained();
    while (text_q.size() != 0 || s_tvalid || token_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_limit(logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] limits [6];
    int         base;
    limits = '{8'd255, 8'd3, 8'd1, 8'd0, 8'($urandom_range(4, 254)), 8'd128};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every operator, empty string, ignored bytes, odd bytes in an
    // unterminated string, a keyword, a bare end of text
    put_text("=+-*/(),''");
    put_char(" ");
    put_char(8'h80);
    put_char(8'h00);
    put_char(CH_DQUOTE);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CH_SQUOTE);
    put_eot();
    put_eot();
    put_text("in\n");
    put_eot();
    wait_drained();

    foreach (limits[p]) begin
      write_limit(limits[p]);
      if (p == 0) begin
        // Overflow of a number; hold the sender until all results are in
        put_digits(TEXT_MAX);
        wait_drained();
        // Full string closed by its quote, then an overlong one
        put_string(TEXT_CAP, 1'b1);
        put_string(TEXT_MAX, 1'b1);
        put_eot();
      end
      base = stim_items;
      while (stim_items - base < PHASE_ITEMS) begin
        repeat ($urandom_range(1, 4)) put_random_token();
        put_eot();
      end
      wait_drained();
    end

    $display("Sent %0d items over %0d token limit settings, including 0, 1 and 255;",
             stim_items, $size(limits) + 1);
    $display("checked %0d results with long tokens, strings and keywords.", res_checked);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results still expected", token_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
src/stt_pkg.sv
src/stt_dp.sv
src/stt_ctrl.sv
src/source_text_tokenizer_top.sv
dv/source_text_tokenizer_top_tb.sv
